[rtl/i2cdw_pkg.sv]
// Shared types and constants for the I2C display write master.
package i2cdw_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ADDR = 2'd0;
  localparam logic [1:0] CFG_CMD  = 2'd1;
  localparam logic [1:0] CFG_DATA = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] ADDR_RESET = 8'h78;
  localparam logic [7:0] CMD_RESET  = 8'h00;
  localparam logic [7:0] DATA_RESET = 8'h40;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // One result of the sequencer, as seen after one input transfer.
  typedef struct packed {
    logic nack_error;
    logic byte_done;
    logic ready_res;
    logic sda_level;
    logic scl_level;
  } res_t;

endpackage

[rtl/i2cdw_seq.sv]
// Bus sequencer: configuration registers, line state and next-state logic.
module i2cdw_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             acc,
  input  logic             tick,
  input  logic             req,
  input  logic             is_data,
  input  logic [7:0]       data_byte,
  input  logic             more_follows,
  input  logic             ignore_nack,
  input  logic             sda_sample,
  output i2cdw_pkg::res_t  res
);
  import i2cdw_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START1 = 3'd1;
  localparam logic [2:0] PH_START2 = 3'd2;
  localparam logic [2:0] PH_BYTE   = 3'd3;
  localparam logic [2:0] PH_HOLD   = 3'd4;
  localparam logic [2:0] PH_STOP1  = 3'd5;
  localparam logic [2:0] PH_STOP2  = 3'd6;
  localparam logic [2:0] PH_STOP3  = 3'd7;

  localparam logic [1:0] STG_ADDR = 2'd0;
  localparam logic [1:0] STG_CTRL = 2'd1;
  localparam logic [1:0] STG_DATA = 2'd2;

  localparam logic [2:0] SUB_LOW  = 3'd0;
  localparam logic [2:0] SUB_HIGH = 3'd1;
  localparam logic [2:0] SUB_ACKL = 3'd2;
  localparam logic [2:0] SUB_ACKH = 3'd3;
  localparam logic [2:0] SUB_ACKC = 3'd4;

  logic [7:0] addr_r, cmd_r, dctl_r;
  logic [2:0] phase_r, phase_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] held_r, held_nxt;
  logic       hdata_r, hdata_nxt;
  logic       hmore_r, hmore_nxt;
  logic       hign_r, hign_nxt;
  logic       open_r, open_nxt;
  logic       disc_r, disc_nxt;
  logic       err_r, err_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       done;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
      cmd_r  <= CMD_RESET;
      dctl_r <= DATA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADDR: addr_r <= cfg_data;
        CFG_CMD:  cmd_r  <= cfg_data;
        CFG_DATA: dctl_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Next state for one accepted transfer. A request taken in idle or hold consumes the step.
  always_comb begin
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    sub_nxt   = sub_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    held_nxt  = held_r;
    hdata_nxt = hdata_r;
    hmore_nxt = hmore_r;
    hign_nxt  = hign_r;
    open_nxt  = open_r;
    disc_nxt  = disc_r;
    err_nxt   = err_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    done      = 1'b0;
    if (acc) begin
      if (req && phase_r == PH_IDLE) begin
        if (disc_r) begin
          // Drop the byte while the rest of an aborted burst drains.
          done     = 1'b1;
          disc_nxt = more_follows;
        end else begin
          held_nxt  = data_byte;
          hdata_nxt = is_data;
          hmore_nxt = more_follows;
          hign_nxt  = ignore_nack;
          open_nxt  = 1'b1;
          phase_nxt = PH_START1;
        end
      end else if (req && phase_r == PH_HOLD) begin
        // Bus still open: go straight to the data byte.
        held_nxt  = data_byte;
        hdata_nxt = is_data;
        hmore_nxt = more_follows;
        hign_nxt  = ignore_nack;
        shift_nxt = data_byte;
        bit_nxt   = 3'd0;
        phase_nxt = PH_BYTE;
        stage_nxt = STG_DATA;
        sub_nxt   = SUB_LOW;
      end else if (tick) begin
        unique case (phase_r)
          PH_IDLE, PH_HOLD: ;
          PH_START1: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
            phase_nxt = PH_START2;
          end
          PH_START2: begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            shift_nxt = addr_r;
            bit_nxt   = 3'd0;
            phase_nxt = PH_BYTE;
            stage_nxt = STG_ADDR;
            sub_nxt   = SUB_LOW;
          end
          PH_BYTE: begin
            case (sub_r)
              SUB_LOW: begin
                scl_nxt = 1'b0;
                sda_nxt = shift_r[7];
                sub_nxt = SUB_HIGH;
              end
              SUB_HIGH: begin
                scl_nxt = 1'b1;
                if (bit_r == 3'd7) begin
                  sub_nxt = SUB_ACKL;
                end else begin
                  bit_nxt   = bit_r + 3'd1;
                  shift_nxt = {shift_r[6:0], 1'b0};
                  sub_nxt   = SUB_LOW;
                end
              end
              SUB_ACKL: begin
                scl_nxt = 1'b0;
                sda_nxt = 1'b1;
                sub_nxt = SUB_ACKH;
              end
              SUB_ACKH: begin
                scl_nxt = 1'b1;
                sda_nxt = 1'b1;
                sub_nxt = SUB_ACKC;
              end
              SUB_ACKC: begin
                scl_nxt = 1'b0;
                sda_nxt = 1'b1;
                if (sda_sample && !hign_r) begin
                  // Missing acknowledge: abort with a stop.
                  err_nxt   = 1'b1;
                  disc_nxt  = hmore_r;
                  done      = 1'b1;
                  phase_nxt = PH_STOP1;
                end else if (stage_r == STG_ADDR) begin
                  shift_nxt = hdata_r ? dctl_r : cmd_r;
                  bit_nxt   = 3'd0;
                  stage_nxt = STG_CTRL;
                  sub_nxt   = SUB_LOW;
                end else if (stage_r == STG_CTRL) begin
                  shift_nxt = held_r;
                  bit_nxt   = 3'd0;
                  stage_nxt = STG_DATA;
                  sub_nxt   = SUB_LOW;
                end else begin
                  done      = 1'b1;
                  phase_nxt = hmore_r ? PH_HOLD : PH_STOP1;
                end
              end
              default: begin
                phase_nxt = PH_IDLE;
                open_nxt  = 1'b0;
                scl_nxt   = 1'b1;
                sda_nxt   = 1'b1;
              end
            endcase
          end
          PH_STOP1: begin
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            phase_nxt = PH_STOP2;
          end
          PH_STOP2: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
            phase_nxt = PH_STOP3;
          end
          PH_STOP3: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            open_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
          end
          default: ;
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      stage_r <= STG_ADDR;
      sub_r   <= SUB_LOW;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      held_r  <= 8'd0;
      hdata_r <= 1'b0;
      hmore_r <= 1'b0;
      hign_r  <= 1'b0;
      open_r  <= 1'b0;
      disc_r  <= 1'b0;
      err_r   <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
      sub_r   <= sub_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      held_r  <= held_nxt;
      hdata_r <= hdata_nxt;
      hmore_r <= hmore_nxt;
      hign_r  <= hign_nxt;
      open_r  <= open_nxt;
      disc_r  <= disc_nxt;
      err_r   <= err_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  // Result of this transfer, taken from the state after the step.
  always_comb begin
    res.scl_level  = scl_nxt;
    res.sda_level  = sda_nxt;
    res.ready_res  = (phase_nxt == PH_IDLE) || (phase_nxt == PH_HOLD);
    res.byte_done  = done;
    res.nack_error = err_nxt;
  end

`ifndef SYNTHESIS
  // Both lines are released whenever the bus is idle.
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> scl_r && sda_r)
    else $error("lines not released in idle");

  // The error flag is sticky until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("error flag cleared");

  // Discarding only happens after an abort, never inside a transaction.
  a_disc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> phase_r == PH_IDLE || phase_r == PH_STOP1 ||
               phase_r == PH_STOP2 || phase_r == PH_STOP3)
    else $error("discard set during transaction");

  // Holding the bus means a transaction is open.
  a_hold_open: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HOLD |-> open_r)
    else $error("hold without open bus");
`endif

endmodule

[rtl/i2cdw_out.sv]
// Output register that holds one result until the downstream side takes it.
module i2cdw_out (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  i2cdw_pkg::res_t                      res,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [i2cdw_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import i2cdw_pkg::*;

  localparam int PAD_W = OUT_DATA_W - $bits(res_t);

  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r;

  // A new transfer is taken whenever the register is empty or the held result leaves this cycle.
  assign in_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= {{PAD_W{1'b0}}, res};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

[rtl/i2c_display_write_master.sv]
// Top level of the write-only I2C display master.
// Latency: a result appears in the cycle after its input transfer.
// Throughput: one input transfer per cycle; only output backpressure stalls it.
// Bus bit rate is set by the tick cadence: two ticks per bit, plus ACK slots.
// Reset (rst_n low, synchronous): bus idle, both lines high, error flag clear.
module i2c_display_write_master (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tick[0], request_valid[1], data_byte[9:2], more_follows[10],
  // ignore_nack[11], sda_sample[12], zero[15:13]
  input  logic [i2cdw_pkg::IN_DATA_W-1:0]    in_tdata,
  // is_data[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // scl_level[0], sda_level[1], ready_res[2], byte_done[3],
  // nack_error[4], zero[7:5]
  output logic [i2cdw_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import i2cdw_pkg::*;

  res_t res;
  logic acc;

  assign cfg_ready = 1'b1;
  assign acc       = in_tvalid && in_tready;

  i2cdw_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .acc          (acc),
    .tick         (in_tdata[0]),
    .req          (in_tdata[1]),
    .is_data      (in_tuser),
    .data_byte    (in_tdata[9:2]),
    .more_follows (in_tdata[10]),
    .ignore_nack  (in_tdata[11]),
    .sda_sample   (in_tdata[12]),
    .res          (res)
  );

  i2cdw_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
